>>> design/cte_pkg.sv
// shared constants for the circle/triangle edge contact pipeline
// no dependencies
package cte_pkg;
    localparam int COORD_BITS_DEF       = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int T_FRAC               = 16;
    localparam int NORM_PRE             = 13;
endpackage

>>> design/circle_triangle_edge_contact_top.sv
// circle versus triangle edge contact, fully pipelined
// one query beat in, one contact beat out, depends on cte_pkg
//
// Input channel s_*: one beat carries a circle (center, radius) and three
// triangle vertices in signed Q8.8. Output channel m_*: one beat carries hit
// and the unit contact direction in Q1.14, zero when there is no hit.
// Edges are tried first-second, second-third, third-first; the first edge
// whose closest point lies strictly inside the circle gives the contact.
// The pipeline holds three setup stages, a 16-stage edge parameter divider,
// five stages of contact arithmetic, a one-bit-per-stage square root of
// COORD_BITS + 15 stages, a normalizing divider of NORMAL_FRAC_BITS + 3
// stages and the output register.
// Throughput is one beat per cycle. Every stage holds when the output
// register is full and m_ready is low, so s_ready follows that condition;
// nothing is lost or repeated across a stall.
// Reset clears the valid bits of all stages; the pipeline is then empty.
module circle_triangle_edge_contact_top #(
    parameter int COORD_BITS       = cte_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = cte_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [COORD_BITS-1:0]       s_center_x,
    input  logic signed [COORD_BITS-1:0]       s_center_y,
    input  logic        [COORD_BITS-2:0]       s_circle_radius,
    input  logic signed [COORD_BITS-1:0]       s_first_x,
    input  logic signed [COORD_BITS-1:0]       s_first_y,
    input  logic signed [COORD_BITS-1:0]       s_second_x,
    input  logic signed [COORD_BITS-1:0]       s_second_y,
    input  logic signed [COORD_BITS-1:0]       s_third_x,
    input  logic signed [COORD_BITS-1:0]       s_third_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_hit,
    output logic signed [NORMAL_FRAC_BITS+1:0] m_normal_x,
    output logic signed [NORMAL_FRAC_BITS+1:0] m_normal_y
);
    import cte_pkg::*;

    localparam int EW   = COORD_BITS + 1;
    localparam int PW   = 2 * EW;
    localparam int NW   = PW + 1;
    localparam int TB   = T_FRAC;
    localparam int TW   = TB + 1;
    localparam int MW   = TW + 1 + EW;
    localparam int MVW  = MW + 1;
    localparam int DW   = COORD_BITS + 2;
    localparam int LW   = 2 * DW;
    localparam int R2W  = 2 * (COORD_BITS - 1);
    localparam int SW   = DW + NORM_PRE;
    localparam int RMW  = SW + 3;
    localparam int NF   = NORMAL_FRAC_BITS;
    localparam int NQB  = NF + 2;
    localparam int NNW  = DW + NF + NORM_PRE + 1;
    localparam int OW   = NF + 2;

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    logic signed [COORD_BITS-1:0] px [0:2];
    logic signed [COORD_BITS-1:0] py [0:2];
    assign px[0] = s_first_x;
    assign py[0] = s_first_y;
    assign px[1] = s_second_x;
    assign py[1] = s_second_y;
    assign px[2] = s_third_x;
    assign py[2] = s_third_y;

    // stage 1: edge and offset vectors
    logic                  v1_reg;
    logic signed [EW-1:0]  ex1_reg [0:2];
    logic signed [EW-1:0]  ey1_reg [0:2];
    logic signed [EW-1:0]  wx1_reg [0:2];
    logic signed [EW-1:0]  wy1_reg [0:2];
    logic [COORD_BITS-2:0] r1_reg;

    // stage 2: products
    logic                  v2_reg;
    logic signed [PW-1:0]  pn_x_reg [0:2];
    logic signed [PW-1:0]  pn_y_reg [0:2];
    logic signed [PW-1:0]  pd_x_reg [0:2];
    logic signed [PW-1:0]  pd_y_reg [0:2];
    logic signed [EW-1:0]  ex2_reg [0:2];
    logic signed [EW-1:0]  ey2_reg [0:2];
    logic signed [EW-1:0]  wx2_reg [0:2];
    logic signed [EW-1:0]  wy2_reg [0:2];
    logic [R2W-1:0]        r2_2_reg;

    // edge parameter divider, index 0 is the setup stage
    logic                 dv_reg   [0:TB];
    logic [NW-1:0]        drem_reg [0:TB][0:2];
    logic [NW-1:0]        dden_reg [0:TB][0:2];
    logic [TB-1:0]        dq_reg   [0:TB][0:2];
    logic                 dzero_reg[0:TB][0:2];
    logic                 dfull_reg[0:TB][0:2];
    logic signed [EW-1:0] dex_reg  [0:TB][0:2];
    logic signed [EW-1:0] dey_reg  [0:TB][0:2];
    logic signed [EW-1:0] dwx_reg  [0:TB][0:2];
    logic signed [EW-1:0] dwy_reg  [0:TB][0:2];
    logic [R2W-1:0]       dr2_reg  [0:TB];

    // contact arithmetic
    logic                  vm_reg, vr_reg, vq_reg, vl_reg;
    logic signed [MW-1:0]  pmx_reg [0:2];
    logic signed [MW-1:0]  pmy_reg [0:2];
    logic signed [EW-1:0]  mwx_reg [0:2];
    logic signed [EW-1:0]  mwy_reg [0:2];
    logic [R2W-1:0]        mr2_reg, rr2_reg, qr2_reg;
    logic signed [DW-1:0]  rdx_reg [0:2];
    logic signed [DW-1:0]  rdy_reg [0:2];
    logic signed [LW-1:0]  sqx_reg [0:2];
    logic signed [LW-1:0]  sqy_reg [0:2];
    logic signed [DW-1:0]  qdx_reg [0:2];
    logic signed [DW-1:0]  qdy_reg [0:2];
    logic                  lhit_reg [0:2];
    logic [LW-1:0]         llen_reg [0:2];
    logic signed [DW-1:0]  ldx_reg [0:2];
    logic signed [DW-1:0]  ldy_reg [0:2];

    // square root, index 0 is the edge select stage
    logic                 sv_reg   [0:SW];
    logic [2*SW-1:0]      sn_reg   [0:SW];
    logic [RMW-1:0]       srem_reg [0:SW];
    logic [SW-1:0]        sroot_reg[0:SW];
    logic                 shit_reg [0:SW];
    logic                 snz_reg  [0:SW];
    logic signed [DW-1:0] sdx_reg  [0:SW];
    logic signed [DW-1:0] sdy_reg  [0:SW];

    // normalizing divider, index 0 is the setup stage
    logic            nv_reg   [0:NQB];
    logic [SW:0]     nremx_reg[0:NQB];
    logic [SW:0]     nremy_reg[0:NQB];
    logic [NQB-1:0]  nlox_reg [0:NQB];
    logic [NQB-1:0]  nloy_reg [0:NQB];
    logic [NQB-1:0]  nqx_reg  [0:NQB];
    logic [NQB-1:0]  nqy_reg  [0:NQB];
    logic [SW-1:0]   ns_reg   [0:NQB];
    logic            nsx_reg  [0:NQB];
    logic            nsy_reg  [0:NQB];
    logic            nok_reg  [0:NQB];
    logic            nhit_reg [0:NQB];

    logic                  m_valid_reg, m_hit_reg;
    logic signed [OW-1:0]  m_nx_reg, m_ny_reg;

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            vm_reg      <= 1'b0;
            vr_reg      <= 1'b0;
            vq_reg      <= 1'b0;
            vl_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k <= TB; k++) dv_reg[k] <= 1'b0;
            for (int k = 0; k <= SW; k++) sv_reg[k] <= 1'b0;
            for (int k = 0; k <= NQB; k++) nv_reg[k] <= 1'b0;
        end else if (en) begin
            v1_reg    <= s_valid;
            v2_reg    <= v1_reg;
            dv_reg[0] <= v2_reg;
            for (int k = 1; k <= TB; k++) dv_reg[k] <= dv_reg[k-1];
            vm_reg    <= dv_reg[TB];
            vr_reg    <= vm_reg;
            vq_reg    <= vr_reg;
            vl_reg    <= vq_reg;
            sv_reg[0] <= vl_reg;
            for (int k = 1; k <= SW; k++) sv_reg[k] <= sv_reg[k-1];
            nv_reg[0] <= sv_reg[SW];
            for (int k = 1; k <= NQB; k++) nv_reg[k] <= nv_reg[k-1];
            m_valid_reg <= nv_reg[NQB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r1_reg   <= s_circle_radius;
            r2_2_reg <= R2W'(r1_reg * r1_reg);
            dr2_reg[0] <= r2_2_reg;
            for (int k = 1; k <= TB; k++) dr2_reg[k] <= dr2_reg[k-1];
            mr2_reg <= dr2_reg[TB];
            rr2_reg <= mr2_reg;
            qr2_reg <= rr2_reg;
        end
    end

    genvar gi, gk;
    generate
        for (gi = 0; gi < 3; gi++) begin : g_edge
            localparam int J = (gi == 2) ? 0 : gi + 1;
            logic signed [NW-1:0]  num;
            logic [NW-1:0]         den;
            logic [TW-1:0]         t_val;
            logic signed [MVW-1:0] vx, vy;
            logic [LW-1:0]         len2;

            assign num = NW'(pn_x_reg[gi]) + NW'(pn_y_reg[gi]);
            assign den = NW'(pd_x_reg[gi]) + NW'(pd_y_reg[gi]);
            assign t_val = dzero_reg[TB][gi] ? TW'(0) :
                           dfull_reg[TB][gi] ? TW'(1) << TB : {1'b0, dq_reg[TB][gi]};
            assign vx = MVW'(pmx_reg[gi]) - (MVW'(mwx_reg[gi]) <<< TB)
                        + (MVW'(1) <<< (TB - 1));
            assign vy = MVW'(pmy_reg[gi]) - (MVW'(mwy_reg[gi]) <<< TB)
                        + (MVW'(1) <<< (TB - 1));
            assign len2 = LW'(sqx_reg[gi]) + LW'(sqy_reg[gi]);

            always_ff @(posedge aclk) begin
                if (en) begin
                    ex1_reg[gi] <= EW'(px[J]) - EW'(px[gi]);
                    ey1_reg[gi] <= EW'(py[J]) - EW'(py[gi]);
                    wx1_reg[gi] <= EW'(s_center_x) - EW'(px[gi]);
                    wy1_reg[gi] <= EW'(s_center_y) - EW'(py[gi]);

                    pn_x_reg[gi] <= wx1_reg[gi] * ex1_reg[gi];
                    pn_y_reg[gi] <= wy1_reg[gi] * ey1_reg[gi];
                    pd_x_reg[gi] <= ex1_reg[gi] * ex1_reg[gi];
                    pd_y_reg[gi] <= ey1_reg[gi] * ey1_reg[gi];
                    ex2_reg[gi]  <= ex1_reg[gi];
                    ey2_reg[gi]  <= ey1_reg[gi];
                    wx2_reg[gi]  <= wx1_reg[gi];
                    wy2_reg[gi]  <= wy1_reg[gi];

                    drem_reg[0][gi]  <= num;
                    dden_reg[0][gi]  <= den;
                    dq_reg[0][gi]    <= '0;
                    dzero_reg[0][gi] <= (den == '0) || num[NW-1] || (num == '0);
                    dfull_reg[0][gi] <= !num[NW-1] && (num >= den);
                    dex_reg[0][gi]   <= ex2_reg[gi];
                    dey_reg[0][gi]   <= ey2_reg[gi];
                    dwx_reg[0][gi]   <= wx2_reg[gi];
                    dwy_reg[0][gi]   <= wy2_reg[gi];

                    pmx_reg[gi] <= $signed({1'b0, t_val}) * dex_reg[TB][gi];
                    pmy_reg[gi] <= $signed({1'b0, t_val}) * dey_reg[TB][gi];
                    mwx_reg[gi] <= dwx_reg[TB][gi];
                    mwy_reg[gi] <= dwy_reg[TB][gi];

                    rdx_reg[gi] <= vx[TB+DW-1:TB];
                    rdy_reg[gi] <= vy[TB+DW-1:TB];

                    sqx_reg[gi] <= rdx_reg[gi] * rdx_reg[gi];
                    sqy_reg[gi] <= rdy_reg[gi] * rdy_reg[gi];
                    qdx_reg[gi] <= rdx_reg[gi];
                    qdy_reg[gi] <= rdy_reg[gi];

                    lhit_reg[gi] <= len2 < LW'(qr2_reg);
                    llen_reg[gi] <= len2;
                    ldx_reg[gi]  <= qdx_reg[gi];
                    ldy_reg[gi]  <= qdy_reg[gi];
                end
            end

            // one quotient bit per stage
            for (gk = 0; gk < TB; gk++) begin : g_div
                logic [NW-1:0] sh;
                logic          ge;
                assign sh = drem_reg[gk][gi] << 1;
                assign ge = sh >= dden_reg[gk][gi];
                always_ff @(posedge aclk) begin
                    if (en) begin
                        drem_reg[gk+1][gi]  <= ge ? sh - dden_reg[gk][gi] : sh;
                        dq_reg[gk+1][gi]    <= {dq_reg[gk][gi][TB-2:0], ge};
                        dden_reg[gk+1][gi]  <= dden_reg[gk][gi];
                        dzero_reg[gk+1][gi] <= dzero_reg[gk][gi];
                        dfull_reg[gk+1][gi] <= dfull_reg[gk][gi];
                        dex_reg[gk+1][gi]   <= dex_reg[gk][gi];
                        dey_reg[gk+1][gi]   <= dey_reg[gk][gi];
                        dwx_reg[gk+1][gi]   <= dwx_reg[gk][gi];
                        dwy_reg[gk+1][gi]   <= dwy_reg[gk][gi];
                    end
                end
            end
        end
    endgenerate

    // first edge with a hit
    logic                 sel_hit;
    logic [LW-1:0]        sel_len;
    logic signed [DW-1:0] sel_dx, sel_dy;
    always_comb begin
        sel_hit = 1'b1;
        sel_len = llen_reg[2];
        sel_dx  = ldx_reg[2];
        sel_dy  = ldy_reg[2];
        if (lhit_reg[0]) begin
            sel_len = llen_reg[0];
            sel_dx  = ldx_reg[0];
            sel_dy  = ldy_reg[0];
        end else if (lhit_reg[1]) begin
            sel_len = llen_reg[1];
            sel_dx  = ldx_reg[1];
            sel_dy  = ldy_reg[1];
        end else if (!lhit_reg[2]) begin
            sel_hit = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sn_reg[0]    <= {sel_len, (2*NORM_PRE)'(0)};
            srem_reg[0]  <= '0;
            sroot_reg[0] <= '0;
            shit_reg[0]  <= sel_hit;
            snz_reg[0]   <= sel_len != '0;
            sdx_reg[0]   <= sel_dx;
            sdy_reg[0]   <= sel_dy;
        end
    end

    // square root, one root bit per stage
    generate
        for (gk = 0; gk < SW; gk++) begin : g_sqrt
            logic [RMW-1:0] rsh, tst;
            logic           ge;
            assign rsh = {srem_reg[gk][RMW-3:0], sn_reg[gk][2*SW-1 -: 2]};
            assign tst = {1'b0, sroot_reg[gk], 2'b01};
            assign ge  = rsh >= tst;
            always_ff @(posedge aclk) begin
                if (en) begin
                    sn_reg[gk+1]    <= sn_reg[gk] << 2;
                    srem_reg[gk+1]  <= ge ? rsh - tst : rsh;
                    sroot_reg[gk+1] <= {sroot_reg[gk][SW-2:0], ge};
                    shit_reg[gk+1]  <= shit_reg[gk];
                    snz_reg[gk+1]   <= snz_reg[gk];
                    sdx_reg[gk+1]   <= sdx_reg[gk];
                    sdy_reg[gk+1]   <= sdy_reg[gk];
                end
            end
        end
    endgenerate

    logic [DW-1:0]  magx, magy;
    logic [NNW-1:0] numx, numy;
    logic [SW-1:0]  sroot;
    assign sroot = sroot_reg[SW];
    assign magx  = sdx_reg[SW][DW-1] ? DW'(-sdx_reg[SW]) : DW'(sdx_reg[SW]);
    assign magy  = sdy_reg[SW][DW-1] ? DW'(-sdy_reg[SW]) : DW'(sdy_reg[SW]);
    assign numx  = (NNW'(magx) << (NF + NORM_PRE)) + NNW'(sroot >> 1);
    assign numy  = (NNW'(magy) << (NF + NORM_PRE)) + NNW'(sroot >> 1);

    always_ff @(posedge aclk) begin
        if (en) begin
            nremx_reg[0] <= (SW+1)'(numx >> NQB);
            nremy_reg[0] <= (SW+1)'(numy >> NQB);
            nlox_reg[0]  <= numx[NQB-1:0];
            nloy_reg[0]  <= numy[NQB-1:0];
            nqx_reg[0]   <= '0;
            nqy_reg[0]   <= '0;
            ns_reg[0]    <= sroot;
            nsx_reg[0]   <= sdx_reg[SW][DW-1];
            nsy_reg[0]   <= sdy_reg[SW][DW-1];
            nok_reg[0]   <= shit_reg[SW] && snz_reg[SW] && (sroot != '0);
            nhit_reg[0]  <= shit_reg[SW];
        end
    end

    // normalizing divider, one quotient bit per stage for each component
    generate
        for (gk = 0; gk < NQB; gk++) begin : g_ndiv
            logic [SW:0] shx, shy, sv;
            logic        gex, gey;
            assign sv  = {1'b0, ns_reg[gk]};
            assign shx = {nremx_reg[gk][SW-1:0], nlox_reg[gk][NQB-1]};
            assign shy = {nremy_reg[gk][SW-1:0], nloy_reg[gk][NQB-1]};
            assign gex = shx >= sv;
            assign gey = shy >= sv;
            always_ff @(posedge aclk) begin
                if (en) begin
                    nremx_reg[gk+1] <= gex ? shx - sv : shx;
                    nremy_reg[gk+1] <= gey ? shy - sv : shy;
                    nlox_reg[gk+1]  <= nlox_reg[gk] << 1;
                    nloy_reg[gk+1]  <= nloy_reg[gk] << 1;
                    nqx_reg[gk+1]   <= {nqx_reg[gk][NQB-2:0], gex};
                    nqy_reg[gk+1]   <= {nqy_reg[gk][NQB-2:0], gey};
                    ns_reg[gk+1]    <= ns_reg[gk];
                    nsx_reg[gk+1]   <= nsx_reg[gk];
                    nsy_reg[gk+1]   <= nsy_reg[gk];
                    nok_reg[gk+1]   <= nok_reg[gk];
                    nhit_reg[gk+1]  <= nhit_reg[gk];
                end
            end
        end
    endgenerate

    localparam logic [NQB-1:0] QLIM = NQB'(1) << NF;
    logic [NQB-1:0]       qcx, qcy;
    logic signed [OW-1:0] nx_next, ny_next;
    assign qcx     = (nqx_reg[NQB] > QLIM) ? QLIM : nqx_reg[NQB];
    assign qcy     = (nqy_reg[NQB] > QLIM) ? QLIM : nqy_reg[NQB];
    assign nx_next = !nok_reg[NQB] ? OW'(0) : nsx_reg[NQB] ? -OW'(qcx) : OW'(qcx);
    assign ny_next = !nok_reg[NQB] ? OW'(0) : nsy_reg[NQB] ? -OW'(qcy) : OW'(qcy);

    always_ff @(posedge aclk) begin
        if (en) begin
            m_hit_reg <= nhit_reg[NQB];
            m_nx_reg  <= nx_next;
            m_ny_reg  <= ny_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_hit      = m_hit_reg;
    assign m_normal_x = m_nx_reg;
    assign m_normal_y = m_ny_reg;
endmodule
